>>> rtl/hid_apdu_frame_unpacker_macros.svh
// ----------------------------------------------------------------------------
// hid_apdu_frame_unpacker_macros
// assertion macros used by the deframer front end (hafu_front)
// ----------------------------------------------------------------------------
`ifndef HID_APDU_FRAME_UNPACKER_MACROS_SVH
`define HID_APDU_FRAME_UNPACKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define HAFU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define HAFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HAFU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HAFU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/hafu_pkg.sv
// ----------------------------------------------------------------------------
// hafu_pkg
// types and codes of the hid report deframer
// ----------------------------------------------------------------------------
package hafu_pkg;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHORT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_RUN     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HEADER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SEQ     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LEN     = 3'd5;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_LIMIT = 2'd1;

  localparam logic [7:0]  CHANNEL_BYTE   = 8'h01;
  localparam logic [7:0]  TAG_BYTE       = 8'h05;
  localparam logic [15:0] MAX_LENGTH_RST = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic                data_valid;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [15:0]         message_length;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } res_push_t;

endpackage

>>> rtl/hafu_req_if.sv
// ----------------------------------------------------------------------------
// hafu_req_if
// input item channel: command and report byte
// ----------------------------------------------------------------------------
interface hafu_req_if;
  logic                      valid;
  logic                      ready;
  logic [hafu_pkg::CMD_W-1:0] command;
  logic [7:0]                byte_in;

  modport source (output valid, output command, output byte_in, input ready);
  modport sink (input valid, input command, input byte_in, output ready);
endinterface

>>> rtl/hafu_rsp_if.sv
// ----------------------------------------------------------------------------
// hafu_rsp_if
// result item channel: payload byte and transfer status
// ----------------------------------------------------------------------------
interface hafu_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [7:0]                   data_byte;
  logic                         data_valid;
  logic                         last;
  logic [hafu_pkg::STATUS_W-1:0] status;
  logic [15:0]                  message_length;

  modport source (output valid, output data_byte, output data_valid, output last,
                  output status, output message_length, input ready);
  modport sink (input valid, input data_byte, input data_valid, input last,
                input status, input message_length, output ready);
endinterface

>>> rtl/hafu_cfg_if.sv
// ----------------------------------------------------------------------------
// hafu_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface hafu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hafu_pkg::CFG_INDEX_W-1:0] index;
  logic [hafu_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/hid_apdu_frame_unpacker.sv
// ----------------------------------------------------------------------------
// hid_apdu_frame_unpacker
// deframes a message carried in fixed-size hid reports, one byte per item
// ----------------------------------------------------------------------------
// each result is registered in the result queue before it shows on rsp
// throughput: one item per cycle; req stalls only while the 4-entry result
//   queue is full, so a stalled rsp side holds off input after four results
// reset: synchronous, clears the transfer state to idle, max_length to 65535
//   and wait_limit to 0; no clearing pass, items are taken right after reset
module hid_apdu_frame_unpacker #(
  parameter int REPORT_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst,
  hafu_req_if.sink       req,
  hafu_rsp_if.source     rsp,
  hafu_cfg_if.sink       cfg
);

  hafu_pkg::res_push_t push;
  hafu_pkg::res_t      head;
  logic                full;
  logic                not_empty;
  logic                take;

  assign cfg.ready = 1'b1;
  assign req.ready = !full;
  assign take      = req.valid && req.ready;

  hafu_front #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .command   (req.command),
    .byte_in   (req.byte_in),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_push  (push)
  );

  hafu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_push   (push),
    .pop       (rsp.ready),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  assign rsp.valid          = not_empty;
  assign rsp.data_byte      = head.data_byte;
  assign rsp.data_valid     = head.data_valid;
  assign rsp.last           = head.last;
  assign rsp.status         = head.status;
  assign rsp.message_length = head.message_length;

endmodule

>>> rtl/hafu_front.sv
// ----------------------------------------------------------------------------
// hafu_front
// takes one command per cycle while take is high, tracks report position and emits results
// ----------------------------------------------------------------------------
`include "hid_apdu_frame_unpacker_macros.svh"

module hafu_front #(
  parameter int REPORT_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [hafu_pkg::CMD_W-1:0]          command,
  input  logic [7:0]                          byte_in,
  input  logic                                cfg_we,
  input  logic [hafu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hafu_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hafu_pkg::res_push_t                 out_push
);

  localparam int POS_W = $clog2(REPORT_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPORT_BYTES - 1);

  localparam logic PH_IDLE   = 1'b0;
  localparam logic PH_ACTIVE = 1'b1;

  logic        phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic        first, first_next;
  logic [15:0] exp_seq, exp_seq_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] acc, acc_next;
  logic [15:0] ann_len, ann_len_next;
  logic [31:0] wait_cnt, wait_cnt_next;
  logic [15:0] max_length;
  logic [31:0] wait_limit;

  logic [15:0] field_word;
  logic [15:0] rem_dec;
  logic [31:0] wait_inc;
  logic [POS_W-1:0] payload_start;
  logic [7:0]  header_want;
  logic        advance;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_dv;
  logic [hafu_pkg::STATUS_W-1:0] emit_status;

  assign field_word    = {acc[7:0], byte_in};
  assign rem_dec       = remaining - 16'd1;
  assign wait_inc      = (wait_cnt == 32'hFFFF_FFFF) ? wait_cnt : wait_cnt + 32'd1;
  assign payload_start = first ? POS_W'(7) : POS_W'(5);
  assign header_want   = (pos == POS_W'(2)) ? hafu_pkg::TAG_BYTE : hafu_pkg::CHANNEL_BYTE;

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    first_next     = first;
    exp_seq_next   = exp_seq;
    remaining_next = remaining;
    acc_next       = acc;
    ann_len_next   = ann_len;
    wait_cnt_next  = wait_cnt;
    advance        = 1'b0;
    emit           = 1'b0;
    emit_byte      = 8'd0;
    emit_dv        = 1'b0;
    emit_status    = hafu_pkg::ST_RUN;

    if (take) begin
      unique case (command)
        hafu_pkg::CMD_BEGIN: begin
          phase_next     = PH_ACTIVE;
          pos_next       = '0;
          first_next     = 1'b1;
          exp_seq_next   = '0;
          remaining_next = '0;
          acc_next       = '0;
          ann_len_next   = '0;
          wait_cnt_next  = '0;
        end
        hafu_pkg::CMD_BYTE: begin
          if (phase == PH_ACTIVE) begin
            advance = 1'b1;
            priority if (pos < POS_W'(3)) begin
              if (first && byte_in != header_want) begin
                emit        = 1'b1;
                emit_status = hafu_pkg::ST_HEADER;
              end
            end else if (pos == POS_W'(3)) begin
              acc_next = {8'd0, byte_in};
            end else if (pos == POS_W'(4)) begin
              acc_next = field_word;
              if (field_word != exp_seq) begin
                emit        = 1'b1;
                emit_status = hafu_pkg::ST_SEQ;
              end else begin
                exp_seq_next = exp_seq + 16'd1;
              end
            end else if (first && pos == POS_W'(5)) begin
              acc_next = {8'd0, byte_in};
            end else if (first && pos == POS_W'(6)) begin
              acc_next       = field_word;
              ann_len_next   = field_word;
              remaining_next = field_word;
              if (field_word > max_length) begin
                emit        = 1'b1;
                emit_status = hafu_pkg::ST_LEN;
              end else if (field_word == 16'd0) begin
                emit        = 1'b1;
                emit_status = hafu_pkg::ST_OK;
              end
            end else if (pos >= payload_start) begin
              remaining_next = rem_dec;
              emit           = 1'b1;
              emit_byte      = byte_in;
              emit_dv        = 1'b1;
              emit_status    = (rem_dec == 16'd0) ? hafu_pkg::ST_OK : hafu_pkg::ST_RUN;
            end
            // an ending result leaves position untouched
            if (emit && emit_status != hafu_pkg::ST_RUN) begin
              advance = 1'b0;
            end
            if (advance) begin
              if (pos == POS_LAST) begin
                pos_next      = '0;
                first_next    = 1'b0;
                wait_cnt_next = '0;
              end else begin
                pos_next = pos + POS_W'(1);
              end
            end
          end
        end
        hafu_pkg::CMD_SHORT: begin
          if (phase == PH_ACTIVE) begin
            emit        = 1'b1;
            emit_status = hafu_pkg::ST_TIMEOUT;
          end
        end
        hafu_pkg::CMD_TICK: begin
          if (phase == PH_ACTIVE && wait_limit != 32'd0) begin
            wait_cnt_next = wait_inc;
            if (wait_inc >= wait_limit) begin
              emit        = 1'b1;
              emit_status = hafu_pkg::ST_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
      if (emit && emit_status != hafu_pkg::ST_RUN) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_comb begin
    out_push.push                   = emit;
    out_push.res.data_byte          = emit_byte;
    out_push.res.data_valid         = emit_dv;
    out_push.res.last               = (emit_status != hafu_pkg::ST_RUN);
    out_push.res.status             = emit_status;
    out_push.res.message_length     = ann_len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      pos        <= '0;
      first      <= 1'b1;
      exp_seq    <= '0;
      remaining  <= '0;
      acc        <= '0;
      ann_len    <= '0;
      wait_cnt   <= '0;
      max_length <= hafu_pkg::MAX_LENGTH_RST;
      wait_limit <= '0;
    end else begin
      phase     <= phase_next;
      pos       <= pos_next;
      first     <= first_next;
      exp_seq   <= exp_seq_next;
      remaining <= remaining_next;
      acc       <= acc_next;
      ann_len   <= ann_len_next;
      wait_cnt  <= wait_cnt_next;
      if (cfg_we && cfg_index == hafu_pkg::REG_MAX_LENGTH) begin
        max_length <= cfg_data[15:0];
      end
      if (cfg_we && cfg_index == hafu_pkg::REG_WAIT_LIMIT) begin
        wait_limit <= cfg_data;
      end
    end
  end

  // results only come out of an active transfer
  `HAFU_ASSERT_IMPL(a_emit_active, clk, rst, emit, phase == PH_ACTIVE)
  // payload bytes only carry running or success
  `HAFU_ASSERT_IMPL(a_dv_status, clk, rst, emit && emit_dv, emit_status == hafu_pkg::ST_RUN || emit_status == hafu_pkg::ST_OK)
  // an ending result drops the transfer to idle
  `HAFU_ASSERT_NEXT(a_idle_after_end, clk, rst, emit && emit_status != hafu_pkg::ST_RUN, phase == PH_IDLE)

endmodule

>>> rtl/hafu_queue.sv
// ----------------------------------------------------------------------------
// hafu_queue
// short result queue between the deframer and the output channel
// ----------------------------------------------------------------------------
module hafu_queue (
  input  logic                clk,
  input  logic                rst,
  input  hafu_pkg::res_push_t in_push,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output hafu_pkg::res_t      head
);

  localparam int DEPTH = hafu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hafu_pkg::res_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = in_push.push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= in_push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives hid report byte streams into the deframer, predicts every payload
// byte and outcome in a cycle-free model and checks the result items in order
// ----------------------------------------------------------------------------
module tb_top;

  localparam int REPORT_BYTES = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 550;
  localparam int LONG_STALL   = 80;

  typedef struct packed {
    logic [hafu_pkg::CMD_W-1:0] command;
    logic [7:0]                 byte_in;
  } frame_item_t;

  typedef enum int {
    FLAW_NONE, FLAW_HEADER, FLAW_SEQ, FLAW_SHORT, FLAW_RESTART, FLAW_STOP
  } flaw_t;

  logic clk;
  logic rst;

  hafu_req_if req_if();
  hafu_rsp_if rsp_if();
  hafu_cfg_if cfg_if();

  hid_apdu_frame_unpacker #(.REPORT_BYTES(REPORT_BYTES)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  frame_item_t    report_items[$];
  hafu_pkg::res_t expected_deframed[$];

  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned sent_items     = 0;
  int unsigned stall_left     = 0;
  bit          req_took       = 0;
  bit          cfg_took       = 0;
  bit          no_idle        = 0;
  bit          long_stall_req = 0;

  // deframer model state and registers
  bit          xfer_active;
  logic [5:0]  rpt_pos;
  logic [15:0] want_seq;
  logic [15:0] left_bytes;
  logic [15:0] field_acc;
  logic [15:0] len_seen;
  logic [31:0] tick_count;
  bit          first_report;
  logic [15:0] cap_bytes;
  logic [31:0] tick_limit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic open_transfer();
    xfer_active  = 1'b1;
    rpt_pos      = '0;
    want_seq     = '0;
    left_bytes   = '0;
    field_acc    = '0;
    len_seen     = '0;
    tick_count   = '0;
    first_report = 1'b1;
  endtask

  task automatic post_result(input logic [7:0] data, input logic valid,
                             input logic [hafu_pkg::STATUS_W-1:0] status);
    hafu_pkg::res_t r;
    r.data_byte      = valid ? data : 8'h00;
    r.data_valid     = valid;
    r.last           = (status != hafu_pkg::ST_RUN);
    r.status         = status;
    r.message_length = len_seen;
    expected_deframed.push_back(r);
    if (r.last) xfer_active = 1'b0;
  endtask

  task automatic deframe_step(input logic [hafu_pkg::CMD_W-1:0] cmd, input logic [7:0] b);
    int pos;
    int pay_start;
    if (cmd == hafu_pkg::CMD_BEGIN) begin
      open_transfer();
      return;
    end
    if (!xfer_active) return;
    if (cmd == hafu_pkg::CMD_SHORT) begin
      post_result(8'h00, 1'b0, hafu_pkg::ST_TIMEOUT);
      return;
    end
    if (cmd == hafu_pkg::CMD_TICK) begin
      if (tick_limit != 0) begin
        if (tick_count != 32'hFFFF_FFFF) tick_count++;
        if (tick_count >= tick_limit) post_result(8'h00, 1'b0, hafu_pkg::ST_TIMEOUT);
      end
      return;
    end
    pos = int'(rpt_pos);
    pay_start = first_report ? 7 : 5;
    if (pos < 3) begin
      // only the first report carries a checked channel and tag
      if (first_report &&
          b != ((pos == 2) ? hafu_pkg::TAG_BYTE : hafu_pkg::CHANNEL_BYTE)) begin
        post_result(8'h00, 1'b0, hafu_pkg::ST_HEADER);
        return;
      end
    end else if (pos == 3) begin
      field_acc = {8'h00, b};
    end else if (pos == 4) begin
      field_acc = {field_acc[7:0], b};
      if (field_acc != want_seq) begin
        post_result(8'h00, 1'b0, hafu_pkg::ST_SEQ);
        return;
      end
      want_seq = want_seq + 16'd1;
    end else if (first_report && pos == 5) begin
      field_acc = {8'h00, b};
    end else if (first_report && pos == 6) begin
      field_acc  = {field_acc[7:0], b};
      len_seen   = field_acc;
      left_bytes = field_acc;
      if (len_seen > cap_bytes) begin
        post_result(8'h00, 1'b0, hafu_pkg::ST_LEN);
        return;
      end
      if (left_bytes == 0) begin
        post_result(8'h00, 1'b0, hafu_pkg::ST_OK);
        return;
      end
    end else if (pos >= pay_start) begin
      left_bytes = left_bytes - 16'd1;
      if (left_bytes == 0) begin
        post_result(b, 1'b1, hafu_pkg::ST_OK);
        return;
      end
      post_result(b, 1'b1, hafu_pkg::ST_RUN);
    end
    pos++;
    if (pos >= REPORT_BYTES) begin
      pos = 0;
      first_report = 1'b0;
      tick_count = '0;
    end
    rpt_pos = pos[5:0];
  endtask

  // sender: one item per handshake, random gaps
  always @(negedge clk) begin
    frame_item_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_took) begin
      if (report_items.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
        nxt = report_items.pop_front();
        req_if.valid   <= 1'b1;
        req_if.command <= nxt.command;
        req_if.byte_in <= nxt.byte_in;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (long_stall_req) begin
        stall_left = LONG_STALL;
        long_stall_req = 1'b0;
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= no_idle || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    hafu_pkg::res_t seen;
    hafu_pkg::res_t want;
    bit             bad;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      req_took = req_if.valid && req_if.ready;
      cfg_took = cfg_if.valid && cfg_if.ready;
      if (rst) begin
        cap_bytes  = hafu_pkg::MAX_LENGTH_RST;
        tick_limit = '0;
        open_transfer();
        xfer_active = 1'b0;
      end else begin
        if (cfg_took) begin
          case (cfg_if.index)
            hafu_pkg::REG_MAX_LENGTH: cap_bytes = cfg_if.data[15:0];
            hafu_pkg::REG_WAIT_LIMIT: tick_limit = cfg_if.data;
            default: ;
          endcase
        end
        if (req_took) deframe_step(req_if.command, req_if.byte_in);
        if (rsp_if.valid && rsp_if.ready) begin
          seen.data_byte      = rsp_if.data_byte;
          seen.data_valid     = rsp_if.data_valid;
          seen.last           = rsp_if.last;
          seen.status         = rsp_if.status;
          seen.message_length = rsp_if.message_length;
          if (expected_deframed.size() == 0) begin
            $error("unexpected item: data_byte %0h status %0d", seen.data_byte, seen.status);
            error_count++;
          end else begin
            want = expected_deframed.pop_front();
            bad = 1'b0;
            if (seen.data_byte !== want.data_byte) begin
              $error("data_byte: expected %0h, actual %0h", want.data_byte, seen.data_byte);
              bad = 1'b1;
            end
            if (seen.data_valid !== want.data_valid) begin
              $error("data_valid: expected %0d, actual %0d", want.data_valid, seen.data_valid);
              bad = 1'b1;
            end
            if (seen.last !== want.last) begin
              $error("last: expected %0d, actual %0d", want.last, seen.last);
              bad = 1'b1;
            end
            if (seen.status !== want.status) begin
              $error("status: expected %0d, actual %0d", want.status, seen.status);
              bad = 1'b1;
            end
            if (seen.message_length !== want.message_length) begin
              $error("message_length: expected %0h, actual %0h",
                     want.message_length, seen.message_length);
              bad = 1'b1;
            end
            if (bad) error_count++;
          end
        end
      end
    end
  end

  task automatic push_item(input logic [hafu_pkg::CMD_W-1:0] cmd, input logic [7:0] b);
    frame_item_t it;
    it.command = cmd;
    it.byte_in = b;
    report_items.push_back(it);
    sent_items++;
  endtask

  task automatic write_reg(input logic [hafu_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [hafu_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // sender pauses here until every predicted item has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (report_items.size() != 0 || req_if.valid || expected_deframed.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one transfer: begin, first report, continuation reports, optional flaw
  task automatic queue_message(input int unsigned len, input flaw_t flaw,
                               input int unsigned tick_pct, input bit pad);
    logic [7:0]  stream[$];
    logic [15:0] alen;
    logic [15:0] seq_no;
    int unsigned payload, sent, rpt, pos, at, k, n;
    alen = len[15:0];
    payload = (len <= 250) ? len : 57;
    sent = 0;
    rpt = 0;
    do begin
      seq_no = rpt[15:0];
      for (pos = 0; pos < REPORT_BYTES; pos++) begin
        if (rpt == 0 && pos < 3) begin
          stream.push_back((pos == 2) ? hafu_pkg::TAG_BYTE : hafu_pkg::CHANNEL_BYTE);
        end else if (pos < 3) begin
          stream.push_back(8'($urandom_range(255)));
        end else if (pos == 3) begin
          stream.push_back(seq_no[15:8]);
        end else if (pos == 4) begin
          stream.push_back(seq_no[7:0]);
        end else if (rpt == 0 && pos == 5) begin
          stream.push_back(alen[15:8]);
        end else if (rpt == 0 && pos == 6) begin
          stream.push_back(alen[7:0]);
        end else if (sent < payload) begin
          stream.push_back(8'($urandom_range(255)));
          sent++;
        end else if (pad) begin
          stream.push_back(8'($urandom_range(255)));
        end else begin
          break;
        end
      end
      rpt++;
    end while (sent < payload);

    at = $urandom_range(stream.size() - 1);
    case (flaw)
      FLAW_HEADER: begin
        at = $urandom_range(2);
        stream[at] = stream[at] ^ 8'($urandom_range(255, 1));
      end
      FLAW_SEQ: begin
        at = $urandom_range(rpt - 1) * REPORT_BYTES + 3 + $urandom_range(1);
        if (at < stream.size()) stream[at] = stream[at] ^ 8'($urandom_range(255, 1));
      end
      default: ;
    endcase

    push_item(hafu_pkg::CMD_BEGIN, 8'($urandom_range(255)));
    for (k = 0; k < stream.size(); k++) begin
      if (flaw == FLAW_STOP && k == at) break;
      if (flaw == FLAW_SHORT && k == at)
        push_item(hafu_pkg::CMD_SHORT, 8'($urandom_range(255)));
      if (flaw == FLAW_RESTART && k == at)
        push_item(hafu_pkg::CMD_BEGIN, 8'($urandom_range(255)));
      if ($urandom_range(99) < tick_pct) begin
        for (n = $urandom_range(3, 1); n != 0; n--)
          push_item(hafu_pkg::CMD_TICK, 8'($urandom_range(255)));
      end
      push_item(hafu_pkg::CMD_BYTE, stream[k]);
    end
  endtask

  initial begin
    int unsigned phase_no, msgs, m, r, len, tick_pct;
    logic [15:0] cap;
    logic [31:0] lim;
    flaw_t       flaw;

    req_if.valid   = 1'b0;
    req_if.command = hafu_pkg::CMD_BEGIN;
    req_if.byte_in = 8'h00;
    rsp_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = hafu_pkg::REG_MAX_LENGTH;
    cfg_if.data    = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ignored while idle
    push_item(hafu_pkg::CMD_TICK, 8'h00);
    push_item(hafu_pkg::CMD_SHORT, 8'hFF);
    // zero length ends at the length field
    push_item(hafu_pkg::CMD_BEGIN, 8'h00);
    push_item(hafu_pkg::CMD_BYTE, hafu_pkg::CHANNEL_BYTE);
    push_item(hafu_pkg::CMD_BYTE, hafu_pkg::CHANNEL_BYTE);
    push_item(hafu_pkg::CMD_BYTE, hafu_pkg::TAG_BYTE);
    push_item(hafu_pkg::CMD_BYTE, 8'h00);
    push_item(hafu_pkg::CMD_BYTE, 8'h00);
    push_item(hafu_pkg::CMD_BYTE, 8'h00);
    push_item(hafu_pkg::CMD_BYTE, 8'h00);
    // bad channel on the first byte
    push_item(hafu_pkg::CMD_BEGIN, 8'hFF);
    push_item(hafu_pkg::CMD_BYTE, 8'h00);
    // first report with sequence 1
    push_item(hafu_pkg::CMD_BEGIN, 8'h00);
    push_item(hafu_pkg::CMD_BYTE, hafu_pkg::CHANNEL_BYTE);
    push_item(hafu_pkg::CMD_BYTE, hafu_pkg::CHANNEL_BYTE);
    push_item(hafu_pkg::CMD_BYTE, hafu_pkg::TAG_BYTE);
    push_item(hafu_pkg::CMD_BYTE, 8'h00);
    push_item(hafu_pkg::CMD_BYTE, 8'h01);
    // restart while active, then a short report
    push_item(hafu_pkg::CMD_BEGIN, 8'h00);
    push_item(hafu_pkg::CMD_BEGIN, 8'hFF);
    push_item(hafu_pkg::CMD_SHORT, 8'h00);
    wait_drained();

    sent_items = 0;
    phase_no = 0;
    // the first three phases always run: zero length cap, held receiver, then no idling
    while (sent_items < RANDOM_ITEMS || phase_no < 3) begin
      case (phase_no)
        0: begin
          cap = 16'h0000;
          lim = 32'd1;
        end
        1: begin
          cap = 16'hFFFF;
          lim = 32'hFFFF_FFFF;
        end
        2: begin
          cap = 16'd100;
          lim = 32'd4;
        end
        default: begin
          r = $urandom_range(3);
          case (r)
            0: cap = 16'h0000;
            1: cap = 16'hFFFF;
            2: cap = 16'($urandom_range(300));
            default: cap = 16'($urandom_range(65535));
          endcase
          r = $urandom_range(9);
          if (r < 4) lim = 32'd0;
          else if (r == 4) lim = 32'd1;
          else if (r < 8) lim = $urandom_range(30, 2);
          else if (r == 8) lim = $urandom_range(500, 31);
          else lim = 32'hFFFF_FFFF;
        end
      endcase
      write_reg(hafu_pkg::REG_MAX_LENGTH, {16'h0000, cap});
      write_reg(hafu_pkg::REG_WAIT_LIMIT, lim);

      no_idle = (phase_no == 2);
      r = $urandom_range(2);
      tick_pct = (phase_no == 0 || r == 2) ? 10 : (r == 1) ? 3 : 0;

      // results pile up behind a held receiver until input stalls
      if (phase_no == 1) begin
        long_stall_req = 1'b1;
        queue_message(50, FLAW_NONE, 0, 1'b0);
      end
      // two full reports back to back on both sides
      if (phase_no == 2) begin
        queue_message(90, FLAW_NONE, 0, 1'b1);
      end

      msgs = $urandom_range(4, 1);
      for (m = 0; m < msgs && sent_items < RANDOM_ITEMS; m++) begin
        r = $urandom_range(99);
        if (r < 65) len = $urandom_range(56);
        else if (r < 88) len = $urandom_range(180, 57);
        else if (r < 96) len = $urandom_range(65535);
        else len = 65535;
        r = $urandom_range(99);
        if (r < 60) flaw = FLAW_NONE;
        else if (r < 68) flaw = FLAW_HEADER;
        else if (r < 76) flaw = FLAW_SEQ;
        else if (r < 84) flaw = FLAW_SHORT;
        else if (r < 92) flaw = FLAW_RESTART;
        else flaw = FLAW_STOP;
        queue_message(len, flaw, tick_pct, 1'($urandom_range(1)));
        // stray items between transfers
        if ($urandom_range(3) == 0) begin
          for (r = $urandom_range(3, 1); r != 0; r--)
            push_item(2'($urandom_range(3, 1)), 8'($urandom_range(255)));
        end
      end
      wait_drained();
      phase_no++;
    end

    no_idle = 1'b0;
    wait_drained();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/hafu_pkg.sv
rtl/hafu_req_if.sv
rtl/hafu_rsp_if.sv
rtl/hafu_cfg_if.sv
rtl/hafu_front.sv
rtl/hafu_queue.sv
rtl/hid_apdu_frame_unpacker.sv
tb/sv/tb_top.sv
